// ----- hdl/dhcp_pkg.sv -----
`default_nettype none
package dhcp_pkg;
	localparam int MAX_MESSAGE_BYTES = 2048;
	localparam int MAX_ADDRESSES = 4;
	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int CNT_W = $clog2(MAX_ADDRESSES + 1);
	localparam int IDX_W = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;
	localparam int SPAN_W = 11;
	localparam logic [SPAN_W-1:0] SPAN_MAX = '1;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_XID = 2'd1;
	localparam logic [1:0] CFG_MAC = 2'd2;
	localparam logic [1:0] CFG_TIME = 2'd3;

	localparam logic [15:0] OPT_CLIENTID = 16'd1;
	localparam logic [15:0] OPT_SERVERID = 16'd2;
	localparam logic [15:0] OPT_IA_NA = 16'd3;
	localparam logic [15:0] OPT_IAADDR = 16'd5;
	localparam logic [15:0] OPT_DNS = 16'd23;
	localparam logic [15:0] OPT_DOMAIN = 16'd24;

	localparam logic [7:0] MSG_ADVERTISE = 8'd2;
	localparam logic [7:0] MSG_REPLY = 8'd7;
	localparam logic [15:0] DUID_LEN = 16'd14;
	localparam logic [15:0] IANA_MIN = 16'd12;
	localparam logic [15:0] IAADDR_LEN = 16'd24;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic last_byte;
	} in_req_t;

	typedef struct packed {
		logic accepted;
		logic is_address;
		logic [10:0] server_id_offset;
		logic [10:0] server_id_length;
		logic [10:0] dns_offset;
		logic [10:0] dns_length;
		logic [10:0] domain_offset;
		logic [10:0] domain_length;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [63:0] lifetimes;
		logic last_of_run;
	} out_req_t;

	// controller -> datapath
	typedef struct packed {
		logic take_byte;   // parse the input byte
		logic load_out;    // load output register
		logic out_is_addr; // address item vs summary
		logic [IDX_W-1:0] addr_idx;
		logic out_last;
		logic clear;       // end of message
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic acc;
		logic [CNT_W-1:0] addr_count;
	} sts_t;
endpackage
`default_nettype wire

// ----- hdl/dhcp_datapath.sv -----
`default_nettype none
module dhcp_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [47:0] cfg_data,
	input wire dhcp_pkg::in_req_t in_req,
	input wire dhcp_pkg::cmd_t cmd,
	output dhcp_pkg::sts_t sts,
	output dhcp_pkg::out_req_t out_q
);
	import dhcp_pkg::*;

	logic mode_q;
	logic [23:0] xid_q;
	logic [47:0] mac_q;
	logic [31:0] time_q;

	logic [POS_W-1:0] pos_q;
	logic hdr_ok_q, chk_ok_q;
	logic [2:0] ph_q;
	logic [15:0] code_q, len_q, seen_q;
	logic [63:0] shift_q;
	logic [SPAN_W-1:0] sid_off_q, sid_len_q, dns_off_q, dns_len_q, dom_off_q, dom_len_q;
	logic [2:0] sph_q;
	logic [15:0] scode_q, slen_q, sseen_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0] mem_hi [MAX_ADDRESSES];
	logic [63:0] mem_lo [MAX_ADDRESSES];
	logic [63:0] mem_lt [MAX_ADDRESSES];

	logic [7:0] b;
	assign b = in_req.msg_byte;

	function automatic logic [7:0] mac_byte(input logic [47:0] m, input logic [2:0] j);
		logic [7:0] r;
		case (j)
			3'd0: r = m[47:40];
			3'd1: r = m[39:32];
			3'd2: r = m[31:24];
			3'd3: r = m[23:16];
			3'd4: r = m[15:8];
			default: r = m[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [7:0] duid_byte(input logic [3:0] i, input logic [31:0] t,
			input logic [47:0] m);
		logic [7:0] r;
		case (i)
			4'd1, 4'd3: r = 8'd1;
			4'd0, 4'd2: r = 8'd0;
			4'd4: r = t[31:24];
			4'd5: r = t[23:16];
			4'd6: r = t[15:8];
			4'd7: r = t[7:0];
			default: r = mac_byte(m, 3'(i - 4'd8));
		endcase
		return r;
	endfunction

	function automatic logic [SPAN_W-1:0] sat(input logic [16:0] v);
		return (v > 17'(SPAN_MAX)) ? SPAN_MAX : v[SPAN_W-1:0];
	endfunction

	logic [15:0] full_len;
	logic [POS_W:0] pos_next;
	logic [4:0] k;
	logic [IDX_W-1:0] wi;
	assign full_len = {len_q[15:8], b};
	assign pos_next = {1'b0, pos_q} + (POS_W+1)'(1);
	assign k = 5'(sseen_q) + 5'd1;
	assign wi = cnt_q[IDX_W-1:0];

	// final checks folded in after the last byte
	logic fin_ok;
	logic acc_now;
	always_comb begin
		fin_ok = chk_ok_q;
		if (ph_q == 3'd4 && code_q == OPT_CLIENTID) fin_ok = 1'b0;
		if (ph_q == 3'd4 && code_q == OPT_IA_NA && seen_q < 16'd4) fin_ok = 1'b0;
	end
	assign acc_now = hdr_ok_q && fin_ok && (pos_q >= POS_W'(4));
	assign sts = '{acc: acc_now, addr_count: cnt_q};

	// summary request; spans only when the message passed
	out_req_t sum_d;
	always_comb begin
		sum_d = '0;
		sum_d.last_of_run = cmd.out_last;
		if (acc_now) begin
			sum_d.accepted = 1'b1;
			sum_d.server_id_offset = sid_off_q;
			sum_d.server_id_length = sid_len_q;
			sum_d.dns_offset = dns_off_q;
			sum_d.dns_length = dns_len_q;
			sum_d.domain_offset = dom_off_q;
			sum_d.domain_length = dom_len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && pos_q < POS_W'(MAX_MESSAGE_BYTES) && pos_q >= POS_W'(4)
				&& ph_q == 3'd4 && code_q == OPT_IA_NA && seen_q >= IANA_MIN
				&& sph_q == 3'd4 && scode_q == OPT_IAADDR && slen_q >= IAADDR_LEN
				&& sseen_q < IAADDR_LEN && cnt_q < CNT_W'(MAX_ADDRESSES)) begin
			if (k == 5'd8) mem_hi[wi] <= {shift_q[55:0], b};
			if (k == 5'd16) mem_lo[wi] <= {shift_q[55:0], b};
			if (k == 5'd24) mem_lt[wi] <= {shift_q[55:0], b};
		end
		if (cmd.load_out) begin
			if (cmd.out_is_addr) begin
				out_q <= '{accepted: 1'b1, is_address: 1'b1,
					address_high: mem_hi[cmd.addr_idx],
					address_low: mem_lo[cmd.addr_idx],
					lifetimes: mem_lt[cmd.addr_idx],
					last_of_run: cmd.out_last, default: '0};
			end else begin
				out_q <= sum_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0; xid_q <= '0; mac_q <= '0; time_q <= '0;
			pos_q <= '0; hdr_ok_q <= 1'b1; chk_ok_q <= 1'b1; ph_q <= '0;
			code_q <= '0; len_q <= '0; seen_q <= '0; shift_q <= '0;
			sid_off_q <= '0; sid_len_q <= '0; dns_off_q <= '0; dns_len_q <= '0;
			dom_off_q <= '0; dom_len_q <= '0;
			sph_q <= '0; scode_q <= '0; slen_q <= '0; sseen_q <= '0; cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[0];
					CFG_XID: xid_q <= cfg_data[23:0];
					CFG_MAC: mac_q <= cfg_data;
					CFG_TIME: time_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.clear) begin
				pos_q <= '0; hdr_ok_q <= 1'b1; chk_ok_q <= 1'b1; ph_q <= '0;
				code_q <= '0; len_q <= '0; seen_q <= '0; shift_q <= '0;
				sid_off_q <= '0; sid_len_q <= '0; dns_off_q <= '0; dns_len_q <= '0;
				dom_off_q <= '0; dom_len_q <= '0;
				sph_q <= '0; scode_q <= '0; slen_q <= '0; sseen_q <= '0; cnt_q <= '0;
			end else if (cmd.take_byte && pos_q < POS_W'(MAX_MESSAGE_BYTES)) begin
				pos_q <= pos_next[POS_W-1:0];
				if (pos_q == '0) begin
					if (b != (mode_q ? MSG_ADVERTISE : MSG_REPLY)) hdr_ok_q <= 1'b0;
				end else if (pos_q < POS_W'(4)) begin
					if (b != mac_byte({xid_q, 24'd0}, 3'(pos_q - POS_W'(1))))
						hdr_ok_q <= 1'b0;
				end else begin
					case (ph_q)
						3'd0: begin code_q <= {b, 8'd0}; ph_q <= 3'd1; end
						3'd1: begin code_q[7:0] <= b; ph_q <= 3'd2; end
						3'd2: begin len_q <= {b, 8'd0}; ph_q <= 3'd3; end
						3'd3: begin
							len_q <= full_len;
							seen_q <= '0;
							shift_q <= '0;
							ph_q <= (full_len != '0) ? 3'd4 : 3'd0;
							case (code_q)
								OPT_CLIENTID: if (full_len != DUID_LEN) chk_ok_q <= 1'b0;
								OPT_SERVERID: begin
									sid_off_q <= sat(17'(pos_next));
									sid_len_q <= sat({1'b0, full_len});
								end
								OPT_IA_NA: begin
									if (full_len < IANA_MIN) chk_ok_q <= 1'b0;
									cnt_q <= '0;
									sph_q <= '0; scode_q <= '0; slen_q <= '0; sseen_q <= '0;
								end
								OPT_DNS: begin
									dns_off_q <= sat(17'(pos_next));
									dns_len_q <= sat({1'b0, full_len});
								end
								OPT_DOMAIN: begin
									dom_off_q <= sat(17'(pos_next));
									dom_len_q <= sat({1'b0, full_len});
								end
								default: ;
							endcase
						end
						default: begin
							seen_q <= seen_q + 16'd1;
							if (seen_q + 16'd1 == len_q) ph_q <= 3'd0;
							if (code_q == OPT_CLIENTID) begin
								if (seen_q < DUID_LEN && b != duid_byte(seen_q[3:0], time_q, mac_q))
									chk_ok_q <= 1'b0;
							end else if (code_q == OPT_IA_NA) begin
								if (seen_q < 16'd4) begin
									if (b != mac_byte(mac_q, 3'(seen_q[1:0]) + 3'd2))
										chk_ok_q <= 1'b0;
								end else if (seen_q >= IANA_MIN) begin
									case (sph_q)
										3'd0: begin scode_q <= {b, 8'd0}; sph_q <= 3'd1; end
										3'd1: begin scode_q[7:0] <= b; sph_q <= 3'd2; end
										3'd2: begin slen_q <= {b, 8'd0}; sph_q <= 3'd3; end
										3'd3: begin
											slen_q <= {slen_q[15:8], b};
											sseen_q <= '0;
											shift_q <= '0;
											sph_q <= ({slen_q[15:8], b} != '0) ? 3'd4 : 3'd0;
										end
										default: begin
											if (scode_q == OPT_IAADDR && slen_q >= IAADDR_LEN
													&& sseen_q < IAADDR_LEN) begin
												shift_q <= {shift_q[55:0], b};
												if (cnt_q < CNT_W'(MAX_ADDRESSES) && k == 5'd24)
													cnt_q <= cnt_q + CNT_W'(1);
											end
											sseen_q <= sseen_q + 16'd1;
											if (sseen_q + 16'd1 == slen_q) sph_q <= 3'd0;
										end
									endcase
								end
							end
						end
					endcase
				end
			end
		end
	end

	logic unused;
	assign unused = ^{pos_next[POS_W], in_req.last_byte};
endmodule
`default_nettype wire

// ----- hdl/dhcp_ctrl.sv -----
`default_nettype none
module dhcp_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic in_last,
	input wire logic mode_adv,
	output logic out_valid,
	input wire logic out_ready,
	input wire dhcp_pkg::sts_t sts,
	output dhcp_pkg::cmd_t cmd
);
	import dhcp_pkg::*;

	typedef enum logic [1:0] {S_BYTES, S_SUM, S_ADDR} state_t;
	state_t state_q;
	logic [CNT_W-1:0] n_q, i_q;

	logic slot_free;
	assign slot_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_BYTES);

	logic [CNT_W-1:0] n_now;
	assign n_now = (sts.acc && !mode_adv) ? sts.addr_count : '0;

	always_comb begin
		cmd = '0;
		cmd.take_byte = in_valid && in_ready;
		cmd.addr_idx = i_q[IDX_W-1:0];
		if (state_q == S_SUM && slot_free) begin
			cmd.load_out = 1'b1;
			cmd.out_last = (n_now == '0);
			cmd.clear = 1'b1;
		end else if (state_q == S_ADDR && slot_free) begin
			cmd.load_out = 1'b1;
			cmd.out_is_addr = 1'b1;
			cmd.out_last = (i_q + CNT_W'(1) == n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BYTES; out_valid <= 1'b0; n_q <= '0; i_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_BYTES: if (cmd.take_byte && in_last) state_q <= S_SUM;
				S_SUM: if (slot_free) begin
					out_valid <= 1'b1;
					n_q <= n_now;
					i_q <= '0;
					state_q <= (n_now == '0) ? S_BYTES : S_ADDR;
				end
				S_ADDR: if (slot_free) begin
					out_valid <= 1'b1;
					i_q <= i_q + CNT_W'(1);
					if (i_q + CNT_W'(1) == n_q) state_q <= S_BYTES;
				end
				default: state_q <= S_BYTES;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/dhcpv6_reply_option_parser.sv -----
`default_nettype none
// DHCPv6 Advertise/Reply option parser.
// in: one message byte per request (msg_byte, last_byte), valid/ready.
//   Bytes are taken one per cycle while in_ready is high; the byte parser
//   is a single pass, updating all checks and option spans per byte.
// out: after the last byte one summary request, then in Reply mode with
//   an accepted message one request per buffered IAADDR (up to 4),
//   last_of_run marks the end. The summary is loaded from S_SUM once the
//   output register is free; each address request follows from S_ADDR.
// Input is held off while the result run is sent.
// cfg: cfg_we/cfg_index/cfg_data write registers 0..3 (mode, xid, MAC,
//   DUID time); write only while idle.
// Reset clears all message state and the cfg registers, but not the
//   address store or out_data (the store is read only once filled).
// A stalled receiver holds the output register; the run waits for it.
module dhcpv6_reply_option_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [47:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire dhcp_pkg::in_req_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output dhcp_pkg::out_req_t out_data
);
	import dhcp_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic mode_q;

	// mirror of the mode register for run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (cfg_we && cfg_index == CFG_MODE) mode_q <= cfg_data[0];
	end

	dhcp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_last(in_data.last_byte),
		.mode_adv(mode_q), .out_valid, .out_ready, .sts, .cmd
	);

	dhcp_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_req(in_data),
		.cmd, .sts, .out_q(out_data)
	);
endmodule
`default_nettype wire
